/* hdl/subtractive_lagged_rng_macros.svh */
// assertion macros shared by the checker
`ifndef SUBTRACTIVE_LAGGED_RNG_MACROS_SVH
`define SUBTRACTIVE_LAGGED_RNG_MACROS_SVH

// same-cycle implication
`define SLR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slr assertion failed");

// next-cycle implication
`define SLR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slr assertion failed");

`endif

/* hdl/slr_pkg.sv */
package slr_pkg;

   localparam int TABLE_LEN = 55;
   localparam int ADDR_W    = $clog2(TABLE_LEN);
   localparam int DATA_W    = 30;
   localparam int SEED_W    = 32;

   localparam logic [SEED_W-1:0] MODULUS   = 32'd1000000000;
   localparam logic [SEED_W-1:0] SEED_BASE = 32'd161803398;

   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(TABLE_LEN - 1);
   localparam logic [ADDR_W-1:0] SCATTER_STEP = ADDR_W'(21);
   localparam logic [ADDR_W-1:0] WARM_OFFSET  = ADDR_W'(31);
   localparam logic [ADDR_W-1:0] TRAIL_START  = ADDR_W'(31);
   localparam logic [ADDR_W-1:0] TABLE_POS_MAX = ADDR_W'(TABLE_LEN);
   localparam logic [1:0]        LAST_PASS    = 2'd3;

   typedef struct packed {
      logic mag;
      logic absdiff;
      logic mod_step;
      logic fill_init;
      logic fill_step;
      logic warm_rd;
      logic warm_wr;
      logic pointer_init;
      logic draw_rd;
      logic draw_wr;
   } slr_cmd_type;

   typedef struct packed {
      logic mod_done;
      logic fill_last;
      logic warm_last;
      logic out_free;
   } slr_stat_type;

   function automatic logic [DATA_W-1:0] sub_mod(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[DATA_W]) begin
         d = d + MODULUS[DATA_W:0];
      end
      return d[DATA_W-1:0];
   endfunction

endpackage

/* hdl/slr_if.sv */
interface slr_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface slr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [slr_pkg::DATA_W-1:0] random_value;

   modport source (output valid, output random_value, input ready);
   modport sink (input valid, input random_value, output ready);
endinterface

/* hdl/subtractive_lagged_rng.sv */
// draw without reseed: the lag table (two read ports, one write port) is read, then written
// once the output register can take the result, which loads it there; the next request follows that write
// reseeding draw: scattered table fill, then 4 x 55 warm-up steps, each a read then a write
// the next request is taken while the last result still waits in the output register
// synchronous reset clears control, pointers and the seed register; the table is not cleared,
// and the first request after reset always reseeds
module subtractive_lagged_rng (
   input  logic                              clock,
   input  logic                              reset,
   slr_req_if.sink                           req_if,
   slr_rsp_if.source                         rsp_if,
   input  logic                              csr_write_enable,
   input  logic signed [slr_pkg::SEED_W-1:0] csr_write_data
);

   slr_pkg::slr_cmd_type  cmd;
   slr_pkg::slr_stat_type stat;

   slr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_restart (req_if.restart),
      .req_ready   (req_if.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   slr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .rsp_random_value (rsp_if.random_value)
   );

endmodule

/* hdl/slr_ctrl.sv */
module slr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_restart,
   output logic                  req_ready,
   input  slr_pkg::slr_stat_type stat,
   output slr_pkg::slr_cmd_type  cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MAG       = 4'd1;
   localparam logic [3:0] ST_ABS       = 4'd2;
   localparam logic [3:0] ST_MOD       = 4'd3;
   localparam logic [3:0] ST_FILL_INIT = 4'd4;
   localparam logic [3:0] ST_FILL      = 4'd5;
   localparam logic [3:0] ST_WARM_RD   = 4'd6;
   localparam logic [3:0] ST_WARM_WR   = 4'd7;
   localparam logic [3:0] ST_DRAW_RD   = 4'd8;
   localparam logic [3:0] ST_DRAW_WR   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       seeded_ff, seeded_in;

   always_comb begin
      state_in  = state_ff;
      seeded_in = seeded_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart || !seeded_ff) begin
                  state_in = ST_MAG;
               end else begin
                  state_in = ST_DRAW_RD;
               end
            end
         end
         ST_MAG: begin
            cmd.mag  = 1'b1;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            cmd.absdiff = 1'b1;
            state_in    = ST_MOD;
         end
         ST_MOD: begin
            if (stat.mod_done) begin
               state_in = ST_FILL_INIT;
            end else begin
               cmd.mod_step = 1'b1;
            end
         end
         ST_FILL_INIT: begin
            cmd.fill_init = 1'b1;
            state_in      = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_WARM_RD;
            end
         end
         ST_WARM_RD: begin
            cmd.warm_rd = 1'b1;
            state_in    = ST_WARM_WR;
         end
         ST_WARM_WR: begin
            cmd.warm_wr = 1'b1;
            if (stat.warm_last) begin
               cmd.pointer_init = 1'b1;
               seeded_in        = 1'b1;
               state_in         = ST_DRAW_RD;
            end else begin
               state_in = ST_WARM_RD;
            end
         end
         ST_DRAW_RD: begin
            cmd.draw_rd = 1'b1;
            state_in    = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            if (stat.out_free) begin
               cmd.draw_wr = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seeded_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         seeded_ff <= seeded_in;
      end
   end

endmodule

/* hdl/slr_datapath.sv */
module slr_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic signed [slr_pkg::SEED_W-1:0] csr_write_data,
   input  slr_pkg::slr_cmd_type         cmd,
   output slr_pkg::slr_stat_type        stat,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [slr_pkg::DATA_W-1:0]   rsp_random_value
);

   logic [slr_pkg::DATA_W-1:0] mem [slr_pkg::TABLE_LEN];

   logic [slr_pkg::SEED_W-1:0] seed_ff, seed_in;
   logic [slr_pkg::SEED_W-1:0] cur_ff, cur_in;
   logic [slr_pkg::DATA_W-1:0] prev_ff, prev_in;
   logic [slr_pkg::ADDR_W-1:0] pos_ff, pos_in;
   logic [slr_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic [slr_pkg::ADDR_W-1:0] wi_ff, wi_in;
   logic [1:0]                 pass_ff, pass_in;
   logic [slr_pkg::ADDR_W-1:0] lead_ff, lead_in;
   logic [slr_pkg::ADDR_W-1:0] trail_ff, trail_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [slr_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [slr_pkg::DATA_W-1:0] rd_a_ff, rd_b_ff;

   logic [slr_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic [slr_pkg::ADDR_W-1:0] other_addr;
   logic [slr_pkg::ADDR_W:0]   other_sum, pos_sum;
   logic                       we;
   logic [slr_pkg::ADDR_W-1:0] waddr;
   logic [slr_pkg::DATA_W-1:0] wdata;
   logic [slr_pkg::DATA_W-1:0] diff_val;

   function automatic logic [slr_pkg::ADDR_W-1:0] advance(
      input logic [slr_pkg::ADDR_W-1:0] p);
      if (p == slr_pkg::TABLE_POS_MAX) begin
         return slr_pkg::ADDR_W'(1);
      end
      return p + slr_pkg::ADDR_W'(1);
   endfunction

   // position 1..55 after advancing, as a table address
   function automatic logic [slr_pkg::ADDR_W-1:0] next_addr(
      input logic [slr_pkg::ADDR_W-1:0] p);
      if (p == slr_pkg::TABLE_POS_MAX) begin
         return '0;
      end
      return p;
   endfunction

   assign other_sum = {1'b0, wi_ff} + {1'b0, slr_pkg::WARM_OFFSET};
   assign other_addr = (other_sum >= (slr_pkg::ADDR_W + 1)'(slr_pkg::TABLE_LEN)) ?
                       slr_pkg::ADDR_W'(other_sum - (slr_pkg::ADDR_W + 1)'(slr_pkg::TABLE_LEN)) :
                       other_sum[slr_pkg::ADDR_W-1:0];
   assign pos_sum = {1'b0, pos_ff} + {1'b0, slr_pkg::SCATTER_STEP};

   assign rd_addr_a = cmd.draw_rd ? next_addr(lead_ff) : wi_ff;
   assign rd_addr_b = cmd.draw_rd ? next_addr(trail_ff) : other_addr;
   assign diff_val  = slr_pkg::sub_mod(rd_a_ff, rd_b_ff);

   always_comb begin
      seed_in      = seed_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      wi_in        = wi_ff;
      pass_in      = pass_ff;
      lead_in      = lead_ff;
      trail_in     = trail_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;

      if (csr_write_enable) begin
         seed_in = $unsigned(csr_write_data);
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.mag) begin
         cur_in = seed_ff[slr_pkg::SEED_W-1] ? (~seed_ff + slr_pkg::SEED_W'(1)) : seed_ff;
      end
      if (cmd.absdiff) begin
         if (cur_ff > slr_pkg::SEED_BASE) begin
            cur_in = cur_ff - slr_pkg::SEED_BASE;
         end else begin
            cur_in = slr_pkg::SEED_BASE - cur_ff;
         end
      end
      if (cmd.mod_step) begin
         cur_in = cur_ff - slr_pkg::MODULUS;
      end
      if (cmd.fill_init) begin
         we      = 1'b1;
         waddr   = slr_pkg::LAST_ADDR;
         wdata   = cur_ff[slr_pkg::DATA_W-1:0];
         prev_in = slr_pkg::DATA_W'(1);
         pos_in  = slr_pkg::SCATTER_STEP;
         cnt_in  = slr_pkg::ADDR_W'(1);
         wi_in   = '0;
         pass_in = '0;
      end
      if (cmd.fill_step) begin
         we      = 1'b1;
         waddr   = pos_ff - slr_pkg::ADDR_W'(1);
         wdata   = prev_ff;
         prev_in = slr_pkg::sub_mod(cur_ff[slr_pkg::DATA_W-1:0], prev_ff);
         cur_in  = slr_pkg::SEED_W'(prev_ff);
         pos_in  = (pos_sum >= (slr_pkg::ADDR_W + 1)'(slr_pkg::TABLE_LEN)) ?
                   slr_pkg::ADDR_W'(pos_sum - (slr_pkg::ADDR_W + 1)'(slr_pkg::TABLE_LEN)) :
                   pos_sum[slr_pkg::ADDR_W-1:0];
         cnt_in  = cnt_ff + slr_pkg::ADDR_W'(1);
      end
      if (cmd.warm_wr) begin
         we    = 1'b1;
         waddr = wi_ff;
         wdata = diff_val;
         if (wi_ff == slr_pkg::LAST_ADDR) begin
            wi_in   = '0;
            pass_in = pass_ff + 2'd1;
         end else begin
            wi_in = wi_ff + slr_pkg::ADDR_W'(1);
         end
      end
      if (cmd.pointer_init) begin
         lead_in  = '0;
         trail_in = slr_pkg::TRAIL_START;
      end
      if (cmd.draw_rd) begin
         lead_in  = advance(lead_ff);
         trail_in = advance(trail_ff);
      end
      if (cmd.draw_wr) begin
         we           = 1'b1;
         waddr        = lead_ff - slr_pkg::ADDR_W'(1);
         wdata        = diff_val;
         rsp_valid_in = 1'b1;
         rsp_data_in  = diff_val;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.warm_rd || cmd.draw_rd) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         lead_ff      <= '0;
         trail_ff     <= slr_pkg::TRAIL_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         lead_ff      <= lead_in;
         trail_ff     <= trail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      wi_ff       <= wi_in;
      pass_ff     <= pass_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.mod_done  = cur_ff < slr_pkg::MODULUS;
   assign stat.fill_last = cnt_ff == slr_pkg::LAST_ADDR;
   assign stat.warm_last = (wi_ff == slr_pkg::LAST_ADDR) && (pass_ff == slr_pkg::LAST_PASS);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_data_ff;

endmodule

/* hdl/slr_checker.sv */
`include "subtractive_lagged_rng_macros.svh"

module slr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [slr_pkg::DATA_W-1:0] rsp_random_value
);

   // stalled result holds
   `SLR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_random_value))

   // result always below the modulus
   `SLR_ASSERT_IMP(a_rsp_range, clock, reset, rsp_valid, 32'(rsp_random_value) < slr_pkg::MODULUS)

   // one request at a time
   `SLR_ASSERT_NXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)

   // reset empties the output register
   `SLR_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind subtractive_lagged_rng slr_checker u_slr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_random_value (rsp_if.random_value)
);

/* tb/sv/slr_draw_checker.sv */
module slr_draw_checker (
   input  logic                              clock,
   input  logic                              reset,
   slr_req_if                                req_mon,
   slr_rsp_if                                rsp_mon,
   input  logic                              csr_write_enable,
   input  logic signed [slr_pkg::SEED_W-1:0] csr_write_data,
   output int                                mismatch_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     DATA_W       = slr_pkg::DATA_W;
   localparam int     TABLE_LEN    = slr_pkg::TABLE_LEN;
   localparam longint RADIX        = 1000000000;
   localparam longint SEED_ORIGIN  = 161803398;
   localparam int     SPREAD       = 21;
   localparam int     WARM_SHIFT   = 30;
   localparam int     WARM_ROUNDS  = 4;
   localparam int     TRAIL_HOME   = 31;
   localparam int     REPORT_LIMIT = 10;

   logic        [DATA_W-1:0]          lag_mem [1:TABLE_LEN];
   logic        [5:0]                 lead_pos;
   logic        [5:0]                 trail_pos;
   logic                              seeded;
   logic signed [slr_pkg::SEED_W-1:0] seed_reg;
   logic        [DATA_W-1:0]          pending_draws [$];
   int                                mismatches = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = pending_draws.size();

   function automatic logic [DATA_W-1:0] mod_diff(input longint a, input longint b);
      longint d;
      d = a - b;
      if (d < 0) begin
         d += RADIX;
      end
      return DATA_W'(d);
   endfunction

   function automatic logic [5:0] step_pos(input logic [5:0] p);
      return (p >= 6'(TABLE_LEN)) ? 6'd1 : p + 6'd1;
   endfunction

   task automatic reseed();
      longint mag;
      longint cur;
      longint prev;
      int     pos;
      int     other;
      mag = longint'(seed_reg);
      if (mag < 0) begin
         mag = -mag;
      end
      cur = SEED_ORIGIN - mag;
      if (cur < 0) begin
         cur = -cur;
      end
      cur = cur % RADIX;
      lag_mem[TABLE_LEN] = DATA_W'(cur);
      prev = 1;
      // scattered fill
      for (int i = 1; i < TABLE_LEN; i++) begin
         pos = (SPREAD * i) % TABLE_LEN;
         lag_mem[pos] = DATA_W'(prev);
         prev = mod_diff(cur, prev);
         cur = lag_mem[pos];
      end
      // warm-up passes
      for (int k = 0; k < WARM_ROUNDS; k++) begin
         for (int i = 1; i <= TABLE_LEN; i++) begin
            other = 1 + (i + WARM_SHIFT) % TABLE_LEN;
            lag_mem[i] = mod_diff(lag_mem[i], lag_mem[other]);
         end
      end
      lead_pos  = '0;
      trail_pos = 6'(TRAIL_HOME);
      seeded    = 1'b1;
   endtask

   task automatic next_draw(input logic restart_bit, output logic [DATA_W-1:0] value);
      if (restart_bit || !seeded) begin
         reseed();
      end
      lead_pos  = step_pos(lead_pos);
      trail_pos = step_pos(trail_pos);
      value = mod_diff(lag_mem[lead_pos], lag_mem[trail_pos]);
      lag_mem[lead_pos] = value;
   endtask

   always @(posedge clock) begin : watch
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] want;
      if (reset) begin
         foreach (lag_mem[p]) begin
            lag_mem[p] = '0;
         end
         lead_pos  = '0;
         trail_pos = 6'(TRAIL_HOME);
         seeded    = 1'b0;
         seed_reg  = '0;
         pending_draws.delete();
      end else begin
         if (csr_write_enable) begin
            seed_reg = csr_write_data;
         end
         if (req_mon.valid && req_mon.ready) begin
            next_draw(req_mon.restart, value);
            pending_draws.push_back(value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_draws.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result random_value=%0d with no request pending",
                           $realtime, rsp_mon.random_value);
               end
            end else begin
               want = pending_draws.pop_front();
               if (rsp_mon.random_value !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: random_value mismatch: expected %0d, got %0d",
                              $realtime, want, rsp_mon.random_value);
                  end
               end
            end
         end
      end
   end

endmodule

/* tb/sv/subtractive_lagged_rng_tb.sv */
module subtractive_lagged_rng_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_HALF   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_DRAWS  = 250;
   localparam int RESTART_PCT  = 3;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              csr_write_enable;
   logic signed [slr_pkg::SEED_W-1:0] csr_write_data;

   int mismatch_count;
   int pending_count;
   int req_idle_pct      = 0;
   int rsp_idle_pct      = 0;
   int long_holds_asked  = 0;
   int long_holds_done   = 0;
   int hold_left         = 0;
   int quiet_cycles      = 0;
   int draws_sent        = 0;
   int reseeds_sent      = 0;
   int seed_writes       = 0;

   logic signed [slr_pkg::SEED_W-1:0] corner_seeds [6] = '{
      32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd2147483647, 32'sd161803398, -32'sd1, 32'sd1
   };

   slr_req_if req_chan ();
   slr_rsp_if rsp_chan ();

   subtractive_lagged_rng dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_chan),
      .rsp_if           (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   slr_draw_checker draw_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_count    (pending_count)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // result side, with an occasional long hold-off to back the block up
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (long_holds_done < long_holds_asked) begin
         long_holds_done++;
         hold_left = LONG_HOLD - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_draw(input logic restart_bit);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.restart <= restart_bit;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      draws_sent++;
      if (restart_bit) begin
         reseeds_sent++;
      end
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_seed(input logic signed [slr_pkg::SEED_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      seed_writes++;
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 20;
      rsp_idle_pct = 55;
      // first request seeds from the reset value of the seed register
      repeat (3) send_draw(1'b0);
      foreach (corner_seeds[n]) begin
         settle();
         write_seed(corner_seeds[n]);
         send_draw(1'b1);
         send_draw(1'b0);
      end
      // new seed has no effect until a restart
      settle();
      write_seed(32'sd12345);
      send_draw(1'b0);
      send_draw(1'b1);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               req_idle_pct = 20;
               rsp_idle_pct = 55;
            end
            1: begin
               req_idle_pct = 55;
               rsp_idle_pct = 20;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int phase = 0; phase < 2; phase++) begin
            settle();
            write_seed($urandom);
            if (mode == 2 && phase == 0) begin
               long_holds_asked++;
            end
            repeat (PHASE_DRAWS) send_draw($urandom_range(99) < RESTART_PCT);
         end
      end
      settle();

      $display("Covered %0d draw requests, %0d of them with restart, across %0d seed writes",
               draws_sent, reseeds_sent, seed_writes);
      $display("including extreme seeds, three idling patterns and one long result stall");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
